// ----- hw/rtl/tcf_pkg.sv -----
`default_nettype none
package tcf_pkg;

	localparam int ANGLE_FRAC_BITS_DEF   = 12;
	localparam int CORDIC_ITERATIONS_DEF = 16;

	localparam int EST_W   = 24;
	localparam int CFG_IW  = 8;
	localparam int CFG_DW  = 32;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_ROLL_OFS   = 8'd0;
	localparam logic [CFG_IW-1:0] REG_PITCH_OFS  = 8'd1;
	localparam logic [CFG_IW-1:0] REG_GX_OFS     = 8'd2;
	localparam logic [CFG_IW-1:0] REG_GY_OFS     = 8'd3;
	localparam logic [CFG_IW-1:0] REG_GAIN       = 8'd4;
	localparam logic [CFG_IW-1:0] REG_PITCH_THR  = 8'd5;
	localparam logic [CFG_IW-1:0] REG_STEP_SIZE  = 8'd6;
	localparam logic [CFG_IW-1:0] REG_MAX_STEPS  = 8'd7;

	localparam logic KIND_BUTTON = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		AX_IDLE,
		AX_CORDIC,
		AX_ROUND,
		AX_MUL,
		AX_PREP,
		AX_DIV,
		AX_FIN
	} ax_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_START,
		T_RUN,
		T_SPREP,
		T_SDIV,
		T_EMIT
	} top_state_t;

	// arctan(2^-i) in degrees, Q24
	function automatic logic [31:0] atan_q24(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'd754974720;
			5'd1:  v = 32'd445687602;
			5'd2:  v = 32'd235489088;
			5'd3:  v = 32'd119537938;
			5'd4:  v = 32'd60000934;
			5'd5:  v = 32'd30029717;
			5'd6:  v = 32'd15018523;
			5'd7:  v = 32'd7509719;
			5'd8:  v = 32'd3754918;
			5'd9:  v = 32'd1877465;
			5'd10: v = 32'd938734;
			5'd11: v = 32'd469367;
			5'd12: v = 32'd234684;
			5'd13: v = 32'd117342;
			5'd14: v = 32'd58671;
			5'd15: v = 32'd29335;
			5'd16: v = 32'd14668;
			5'd17: v = 32'd7334;
			5'd18: v = 32'd3667;
			5'd19: v = 32'd1833;
			5'd20: v = 32'd917;
			5'd21: v = 32'd458;
			5'd22: v = 32'd229;
			5'd23: v = 32'd115;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tcf_if.sv -----
`default_nettype none
interface tcf_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [21:0] gyro_x;
	logic signed [21:0] gyro_y;
	modport source (output valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y,
		input ready);
	modport sink (input valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y,
		output ready);
endinterface

interface tcf_out_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] roll_steps;
	logic              pitch_up;
	logic              button_pressed;
	modport source (output valid, roll_steps, pitch_up, button_pressed, input ready);
	modport sink (input valid, roll_steps, pitch_up, button_pressed, output ready);
endinterface

interface tcf_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [tcf_pkg::CFG_IW-1:0]  index;
	logic [tcf_pkg::CFG_DW-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tcf_axis.sv -----
`default_nettype none
// One tilt axis: CORDIC atan2, gyro prediction, 49:1 blend with a bit-serial divide by 50.
module tcf_axis #(
	parameter int ANGLE_FRAC_BITS   = tcf_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_ITERATIONS = tcf_pkg::CORDIC_ITERATIONS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire logic signed [15:0]          num,
	input  wire logic signed [15:0]          den,
	input  wire logic signed [21:0]          gyro,
	input  wire logic signed [21:0]          gyro_ofs,
	input  wire logic signed [20:0]          ang_ofs,
	input  wire logic [15:0]                 gain,
	input  wire                              sub_gyro,
	output logic signed [tcf_pkg::EST_W-1:0] est,
	output logic                             done
);
	localparam int NI = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
	localparam int IW = $clog2(NI);
	localparam int XW = 42;
	localparam int ZW = 34;
	localparam int SH = 24 - ANGLE_FRAC_BITS;
	localparam int EW = tcf_pkg::EST_W;
	localparam logic signed [ZW-1:0] Z90 = 34'sd1509949440;
	localparam logic signed [ZW-1:0] ZRND = 34'sd1 <<< (SH - 1);
	localparam logic signed [ZW-1:0] ZLIM = 34'sd180 <<< ANGLE_FRAC_BITS;
	localparam logic signed [39:0] PRND = 40'sd1 <<< (SH - 1);
	localparam logic [40:0] DSAT = 41'd50 << 24;

	tcf_pkg::ax_state_t state_q, state_d;

	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [IW-1:0]        cnt_q;
	logic                 zero_q;
	logic signed [39:0]   p_q;
	logic signed [25:0]   ang_q;
	logic signed [32:0]   pred_q;
	logic signed [39:0]   n_q;
	logic [5:0]           rem_q;
	logic [23:0]          sh_q, quo_q;
	logic [4:0]           dcnt_q;
	logic                 sat_q, neg_q;
	logic signed [EW-1:0] est_q;

	logic signed [XW-1:0] sn, sd, xsh, ysh;
	logic signed [ZW-1:0] atn, zr, zc;
	logic signed [22:0]   rate;
	logic signed [39:0]   delta;
	logic [40:0]          dd;
	logic [6:0]           tr;
	logic                 ge;
	logic [24:0]          nmag;

	assign sn   = {{2{num[15]}}, num, 24'b0};
	assign sd   = {{2{den[15]}}, den, 24'b0};
	assign xsh  = x_q >>> cnt_q;
	assign ysh  = y_q >>> cnt_q;
	assign atn  = ZW'(signed'({1'b0, tcf_pkg::atan_q24(5'(cnt_q))}));
	assign rate = 23'(gyro) - 23'(gyro_ofs);
	assign zr   = (z_q + ZRND) >>> SH;
	assign zc   = (zr > ZLIM) ? ZLIM : ((zr < -ZLIM) ? -ZLIM : zr);
	assign delta = (p_q + PRND) >>> SH;
	assign dd   = n_q[39] ? (41'sd25 - 41'(n_q)) : (41'(n_q) + 41'sd25);
	assign tr   = {rem_q, sh_q[23]};
	assign ge   = tr >= 7'd50;
	assign nmag = {1'b0, quo_q};

	always_comb begin
		state_d = state_q;
		done    = 1'b0;
		case (state_q)
			tcf_pkg::AX_IDLE:   if (start) state_d = tcf_pkg::AX_CORDIC;
			tcf_pkg::AX_CORDIC: if (cnt_q == IW'(NI - 1)) state_d = tcf_pkg::AX_ROUND;
			tcf_pkg::AX_ROUND:  state_d = tcf_pkg::AX_MUL;
			tcf_pkg::AX_MUL:    state_d = tcf_pkg::AX_PREP;
			tcf_pkg::AX_PREP:   state_d = tcf_pkg::AX_DIV;
			tcf_pkg::AX_DIV:    if (dcnt_q == 5'd23) state_d = tcf_pkg::AX_FIN;
			tcf_pkg::AX_FIN: begin
				done    = 1'b1;
				state_d = tcf_pkg::AX_IDLE;
			end
			default: state_d = tcf_pkg::AX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcf_pkg::AX_IDLE;
			est_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tcf_pkg::AX_FIN) begin
				if (sat_q)
					est_q <= neg_q ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
				else if (!neg_q)
					est_q <= quo_q[23] ? {1'b0, {(EW-1){1'b1}}} : {1'b0, quo_q[22:0]};
				else if (nmag > 25'd8388608)
					est_q <= {1'b1, {(EW-1){1'b0}}};
				else
					est_q <= EW'(-nmag);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tcf_pkg::AX_IDLE: begin
				cnt_q  <= '0;
				zero_q <= (num == 16'sd0) && (den == 16'sd0);
				p_q    <= 40'(rate * signed'({1'b0, gain}));
				if (den < 0) begin
					if (num >= 0) begin
						x_q <= sn; y_q <= -sd; z_q <= Z90;
					end else begin
						x_q <= -sn; y_q <= sd; z_q <= -Z90;
					end
				end else begin
					x_q <= sd; y_q <= sn; z_q <= '0;
				end
			end
			tcf_pkg::AX_CORDIC: begin
				cnt_q <= cnt_q + 1'b1;
				if (y_q > 0) begin
					x_q <= x_q + ysh; y_q <= y_q - xsh; z_q <= z_q + atn;
				end else begin
					x_q <= x_q - ysh; y_q <= y_q + xsh; z_q <= z_q - atn;
				end
			end
			tcf_pkg::AX_ROUND: begin
				ang_q  <= zero_q ? -26'(ang_ofs) : 26'(zc) - 26'(ang_ofs);
				pred_q <= sub_gyro ? 33'(est_q) - 33'(delta) : 33'(est_q) + 33'(delta);
			end
			tcf_pkg::AX_MUL: begin
				n_q <= (40'(pred_q) <<< 5) + (40'(pred_q) <<< 4) + 40'(pred_q) + 40'(ang_q);
			end
			tcf_pkg::AX_PREP: begin
				sat_q  <= dd >= DSAT;
				neg_q  <= n_q[39];
				rem_q  <= dd[29:24];
				sh_q   <= dd[23:0];
				dcnt_q <= '0;
			end
			tcf_pkg::AX_DIV: begin
				rem_q  <= ge ? 6'(tr - 7'd50) : tr[5:0];
				quo_q  <= {quo_q[22:0], ge};
				sh_q   <= {sh_q[22:0], 1'b0};
				dcnt_q <= dcnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign est = est_q;

endmodule
`default_nettype wire

// ----- hw/rtl/tilt_complementary_filter.sv -----
`default_nettype none
// Tilt estimator. Each sample word (kind = 1) yields one result word with the roll step
// count, the pitch-over-threshold flag and the button flag; a button word (kind = 0)
// only arms the button flag, which the next result reports and clears. Roll and pitch
// run side by side in two axis units; each sample passes through the one-iteration-per-cycle
// CORDIC (CORDIC_ITERATIONS iterations, max 24) and two bit-serial 24-step dividers
// (blend by 50, then roll by the step size). Input is taken only between samples; a finished
// result sits in the output register, so the next word is accepted while it waits.
// Register writes are taken at any time but belong between samples.
module tilt_complementary_filter #(
	parameter int ANGLE_FRAC_BITS   = tcf_pkg::ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_ITERATIONS = tcf_pkg::CORDIC_ITERATIONS_DEF
) (
	input wire clk,
	input wire arst_n,
	tcf_in_if.sink   sample,
	tcf_out_if.source result,
	tcf_cfg_if.sink  cfg
);
	localparam int EW = tcf_pkg::EST_W;

	tcf_pkg::top_state_t state_q, state_d;

	// configuration
	logic signed [20:0] roll_ofs_q, pitch_ofs_q;
	logic signed [21:0] gx_ofs_q, gy_ofs_q;
	logic [15:0]        gain_q;
	logic [7:0]         thr_q;
	logic [5:0]         step_q;
	logic [6:0]         max_q;

	// captured sample
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [21:0] gx_q, gy_q;

	logic btn_pend_q;

	// roll step divider
	logic [23:0] sa_q, squo_q;
	logic [5:0]  srem_q;
	logic [4:0]  scnt_q;
	logic        sneg_q, pu_q;

	// output register
	logic              res_valid_q;
	logic signed [7:0] roll_q;
	logic              pitch_q, btn_q;

	logic                 ax_start, roll_done, pitch_done;
	logic signed [EW-1:0] roll_est, pitch_est;
	logic                 in_acc, cfg_acc;
	logic [24:0]          rmag;
	logic [5:0]           sdiv;
	logic [6:0]           str, smag;
	logic                 sge;
	logic signed [25:0]   thr_fx;

	assign in_acc  = sample.valid && sample.ready;
	assign cfg_acc = cfg.valid && cfg.ready;
	assign sample.ready = (state_q == tcf_pkg::T_IDLE);
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_ofs_q  <= '0;
			pitch_ofs_q <= '0;
			gx_ofs_q    <= '0;
			gy_ofs_q    <= '0;
			gain_q      <= 16'd419;
			thr_q       <= 8'd15;
			step_q      <= 6'd4;
			max_q       <= 7'd10;
		end else if (cfg_acc) begin
			case (cfg.index)
				tcf_pkg::REG_ROLL_OFS:  roll_ofs_q  <= cfg.data[20:0];
				tcf_pkg::REG_PITCH_OFS: pitch_ofs_q <= cfg.data[20:0];
				tcf_pkg::REG_GX_OFS:    gx_ofs_q    <= cfg.data[21:0];
				tcf_pkg::REG_GY_OFS:    gy_ofs_q    <= cfg.data[21:0];
				tcf_pkg::REG_GAIN:      gain_q      <= cfg.data[15:0];
				tcf_pkg::REG_PITCH_THR: thr_q       <= cfg.data[7:0];
				tcf_pkg::REG_STEP_SIZE: step_q      <= cfg.data[5:0];
				tcf_pkg::REG_MAX_STEPS: max_q       <= cfg.data[6:0];
				default: ;
			endcase
		end
	end

	// roll uses atan2(x, z) and subtracts gyro y; pitch uses atan2(y, z) and adds gyro x
	tcf_axis #(
		.ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_roll (
		.clk(clk), .arst_n(arst_n), .start(ax_start),
		.num(ax_q), .den(az_q), .gyro(gy_q), .gyro_ofs(gy_ofs_q),
		.ang_ofs(roll_ofs_q), .gain(gain_q), .sub_gyro(1'b1),
		.est(roll_est), .done(roll_done)
	);

	tcf_axis #(
		.ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_pitch (
		.clk(clk), .arst_n(arst_n), .start(ax_start),
		.num(ay_q), .den(az_q), .gyro(gx_q), .gyro_ofs(gx_ofs_q),
		.ang_ofs(pitch_ofs_q), .gain(gain_q), .sub_gyro(1'b0),
		.est(pitch_est), .done(pitch_done)
	);

	// |est| >> F divided by step size gives the same truncated quotient as est / (step << F)
	assign rmag   = roll_est[EW-1] ? 25'(-26'(roll_est)) : 25'(roll_est);
	assign sdiv   = (step_q == 6'd0) ? 6'd1 : step_q;
	assign str    = {srem_q, sa_q[23]};
	assign sge    = str >= {1'b0, sdiv};
	assign smag   = (squo_q > 24'(max_q)) ? max_q : squo_q[6:0];
	assign thr_fx = 26'(signed'({1'b0, thr_q})) <<< ANGLE_FRAC_BITS;

	always_comb begin
		state_d  = state_q;
		ax_start = 1'b0;
		case (state_q)
			tcf_pkg::T_IDLE:
				if (in_acc && sample.kind == tcf_pkg::KIND_SAMPLE) state_d = tcf_pkg::T_START;
			tcf_pkg::T_START: begin
				ax_start = 1'b1;
				state_d  = tcf_pkg::T_RUN;
			end
			tcf_pkg::T_RUN:  if (roll_done && pitch_done) state_d = tcf_pkg::T_SPREP;
			tcf_pkg::T_SPREP: state_d = tcf_pkg::T_SDIV;
			tcf_pkg::T_SDIV: if (scnt_q == 5'd23) state_d = tcf_pkg::T_EMIT;
			tcf_pkg::T_EMIT: if (!res_valid_q || result.ready) state_d = tcf_pkg::T_IDLE;
			default: state_d = tcf_pkg::T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcf_pkg::T_IDLE;
			btn_pend_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && sample.kind == tcf_pkg::KIND_BUTTON)
				btn_pend_q <= 1'b1;
			// result load frees the pending flag in the same cycle
			if (state_q == tcf_pkg::T_EMIT && (!res_valid_q || result.ready)) begin
				res_valid_q <= 1'b1;
				btn_pend_q  <= 1'b0;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ax_q <= sample.accel_x;
			ay_q <= sample.accel_y;
			az_q <= sample.accel_z;
			gx_q <= sample.gyro_x;
			gy_q <= sample.gyro_y;
		end
		case (state_q)
			tcf_pkg::T_SPREP: begin
				sa_q   <= 24'(rmag >> ANGLE_FRAC_BITS);
				srem_q <= '0;
				scnt_q <= '0;
				sneg_q <= roll_est[EW-1];
				pu_q   <= 26'(pitch_est) > thr_fx;
			end
			tcf_pkg::T_SDIV: begin
				srem_q <= sge ? 6'(str - {1'b0, sdiv}) : str[5:0];
				squo_q <= {squo_q[22:0], sge};
				sa_q   <= {sa_q[22:0], 1'b0};
				scnt_q <= scnt_q + 1'b1;
			end
			tcf_pkg::T_EMIT: begin
				if (!res_valid_q || result.ready) begin
					roll_q  <= sneg_q ? signed'({1'b0, smag}) : -signed'({1'b0, smag});
					pitch_q <= pu_q;
					btn_q   <= btn_pend_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid          = res_valid_q;
	assign result.roll_steps     = roll_q;
	assign result.pitch_up       = pitch_q;
	assign result.button_pressed = btn_q;

endmodule
`default_nettype wire

// ----- hw/rtl/tcf_checker.sv -----
`default_nettype none
module tcf_checker (
	input wire             clk,
	input wire             arst_n,
	input wire             s_valid,
	input wire             s_ready,
	input wire             s_kind,
	input wire             r_valid,
	input wire             r_ready,
	input wire logic [7:0] r_roll,
	input wire             r_pitch,
	input wire             r_btn
);
	// a held result word stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_roll) && $stable(r_pitch) && $stable(r_btn))
		else $error("result word changed while stalled");

	// a sample occupies the block: input closes the cycle after
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready && s_kind |=> !s_ready)
		else $error("sample accepted but input still open");

	// roll step magnitude never exceeds 127
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> r_roll != 8'h80)
		else $error("roll step out of range");

	// a button word produces no result by itself
	a_btn_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready && !s_kind && !r_valid |=> !r_valid)
		else $error("result after button word");
endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (
	.clk(clk), .arst_n(arst_n),
	.s_valid(sample.valid), .s_ready(sample.ready), .s_kind(sample.kind),
	.r_valid(result.valid), .r_ready(result.ready), .r_roll(result.roll_steps),
	.r_pitch(result.pitch_up), .r_btn(result.button_pressed)
);
`default_nettype wire
